### design/minv_pkg.sv
// Shared widths, cofactor index tables, status codes and the front-end result type.
package minv_pkg;

  localparam int unsigned ELEM_W   = 16;
  localparam int unsigned PROD_W   = 2 * ELEM_W;
  localparam int unsigned ADJ_W    = 2 * ELEM_W + 1;
  localparam int unsigned MAG_W    = 2 * ELEM_W;
  localparam int unsigned DET_W    = 3 * ELEM_W + 3;
  localparam int unsigned DMAG_W   = 3 * ELEM_W + 3;
  localparam int unsigned FRAC     = 24;
  localparam int unsigned NUM_W    = MAG_W + FRAC;
  localparam int unsigned Q_W      = 32;
  localparam int unsigned DETO_W   = 50;
  localparam int unsigned N_ELEM   = 9;
  localparam int unsigned FRONT_LAT = 6;
  localparam int unsigned LANE_LAT  = Q_W + 1;
  localparam int unsigned PIPE_LAT  = FRONT_LAT + LANE_LAT;

  localparam logic [Q_W:0] LIM_POS = {2'b00, {(Q_W - 1){1'b1}}};
  localparam logic [Q_W:0] LIM_NEG = {2'b01, {(Q_W - 1){1'b0}}};
  localparam logic [Q_W-1:0] SAT_POS = {1'b0, {(Q_W - 1){1'b1}}};
  localparam logic [Q_W-1:0] SAT_NEG = {1'b1, {(Q_W - 1){1'b0}}};

  // cofactor k = a[P0] * a[P1] - a[M0] * a[M1], flat row-major indices
  localparam int unsigned CF_P0[N_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int unsigned CF_P1[N_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int unsigned CF_M0[N_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int unsigned CF_M1[N_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SINGULAR = 2'd1,
    ST_SAT      = 2'd2
  } status_t;

  typedef struct packed {
    logic [N_ELEM-1:0][MAG_W-1:0] mag;
    logic [N_ELEM-1:0]            neg;
    logic [DMAG_W-1:0]            dmag;
    logic                         zero;
    logic signed [DET_W-1:0]      det;
  } front_out_t;

endpackage

### design/minv_front.sv
// Cofactor and determinant pipeline: products, adjugate, determinant, sign/magnitude prep.
module minv_front (
  input  logic                                              clk,
  input  logic                                              en,
  input  logic [minv_pkg::N_ELEM-1:0][minv_pkg::ELEM_W-1:0] elem,
  output minv_pkg::front_out_t                              fo
);

  logic signed [minv_pkg::ELEM_W-1:0] a_r   [minv_pkg::N_ELEM];
  logic signed [minv_pkg::PROD_W-1:0] pp_r  [minv_pkg::N_ELEM];
  logic signed [minv_pkg::PROD_W-1:0] pm_r  [minv_pkg::N_ELEM];
  logic signed [minv_pkg::ELEM_W-1:0] t2_r  [3];
  logic signed [minv_pkg::ELEM_W-1:0] t3_r  [3];
  logic signed [minv_pkg::ADJ_W-1:0]  adj_r [minv_pkg::N_ELEM];
  logic signed [minv_pkg::ADJ_W-1:0]  adj4_r[minv_pkg::N_ELEM];
  logic signed [minv_pkg::ADJ_W-1:0]  adj5_r[minv_pkg::N_ELEM];
  logic signed [minv_pkg::DET_W-1:0]  dp_r  [3];
  logic signed [minv_pkg::DET_W-1:0]  det_r;
  minv_pkg::front_out_t               fo_r;
  minv_pkg::front_out_t               fo_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < minv_pkg::N_ELEM; k++) begin
        a_r[k]    <= $signed(elem[k]);
        pp_r[k]   <= minv_pkg::PROD_W'(a_r[minv_pkg::CF_P0[k]]) *
                     minv_pkg::PROD_W'(a_r[minv_pkg::CF_P1[k]]);
        pm_r[k]   <= minv_pkg::PROD_W'(a_r[minv_pkg::CF_M0[k]]) *
                     minv_pkg::PROD_W'(a_r[minv_pkg::CF_M1[k]]);
        adj_r[k]  <= minv_pkg::ADJ_W'(pp_r[k]) - minv_pkg::ADJ_W'(pm_r[k]);
        adj4_r[k] <= adj_r[k];
        adj5_r[k] <= adj4_r[k];
      end
      for (int j = 0; j < 3; j++) begin
        t2_r[j] <= a_r[j];
        t3_r[j] <= t2_r[j];
      end
      dp_r[0] <= minv_pkg::DET_W'(t3_r[0]) * minv_pkg::DET_W'(adj_r[0]);
      dp_r[1] <= minv_pkg::DET_W'(t3_r[1]) * minv_pkg::DET_W'(adj_r[3]);
      dp_r[2] <= minv_pkg::DET_W'(t3_r[2]) * minv_pkg::DET_W'(adj_r[6]);
      det_r   <= dp_r[0] + dp_r[1] + dp_r[2];
      fo_r    <= fo_nxt;
    end
  end

  always_comb begin
    fo_nxt.det  = det_r;
    fo_nxt.zero = (det_r == '0);
    fo_nxt.dmag = det_r[minv_pkg::DET_W-1] ? minv_pkg::DMAG_W'(-det_r)
                                           : minv_pkg::DMAG_W'(det_r);
    for (int k = 0; k < minv_pkg::N_ELEM; k++) begin
      fo_nxt.mag[k] = adj5_r[k][minv_pkg::ADJ_W-1] ? minv_pkg::MAG_W'(-adj5_r[k])
                                                   : minv_pkg::MAG_W'(adj5_r[k]);
      fo_nxt.neg[k] = adj5_r[k][minv_pkg::ADJ_W-1] ^ det_r[minv_pkg::DET_W-1];
    end
  end

  assign fo = fo_r;

endmodule

### design/minv_lane.sv
// One divider lane: pipelined restoring division, one quotient bit per stage, with saturation.
module minv_lane (
  input  logic                          clk,
  input  logic                          en,
  input  logic [minv_pkg::MAG_W-1:0]    mag,
  input  logic [minv_pkg::DMAG_W-1:0]   dmag,
  input  logic                          neg,
  output logic [minv_pkg::Q_W-1:0]      res,
  output logic                          sat
);

  localparam int unsigned QW = minv_pkg::Q_W;
  localparam int unsigned DW = minv_pkg::DMAG_W;
  localparam int unsigned NW = minv_pkg::NUM_W;

  logic [NW-1:0] num;
  logic [DW-1:0] rem_r [QW+1];
  logic [QW-1:0] lo_r  [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic [DW-1:0] dm_r  [QW+1];
  logic          neg_r [QW+1];
  logic          ovf_r [QW+1];
  logic [QW:0]   lim;

  assign num = NW'(mag) << minv_pkg::FRAC;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= DW'(num[NW-1:QW]);
      lo_r[0]  <= num[QW-1:0];
      q_r[0]   <= '0;
      dm_r[0]  <= dmag;
      neg_r[0] <= neg;
      ovf_r[0] <= (DW'(num[NW-1:QW]) >= dmag);
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0] sh;
    logic        ge;
    assign sh = {rem_r[k], lo_r[k][QW-1]};
    assign ge = (sh >= {1'b0, dm_r[k]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? DW'(sh - {1'b0, dm_r[k]}) : DW'(sh);
        lo_r[k+1]  <= {lo_r[k][QW-2:0], 1'b0};
        q_r[k+1]   <= {q_r[k][QW-2:0], ge};
        dm_r[k+1]  <= dm_r[k];
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  always_comb begin
    lim = neg_r[QW] ? minv_pkg::LIM_NEG : minv_pkg::LIM_POS;
    sat = ovf_r[QW] || ({1'b0, q_r[QW]} > lim);
    if (sat) begin
      res = neg_r[QW] ? minv_pkg::SAT_NEG : minv_pkg::SAT_POS;
    end else begin
      res = neg_r[QW] ? -q_r[QW] : q_r[QW];
    end
  end

endmodule

### design/matrix_inverse_3x3.sv
// Top level: 3x3 matrix inverse by adjugate, nine divider lanes and a merging output stage.
//
// Input channel in_valid/in_ready carries one matrix per item: nine signed
// Q8.8 elements in_a00..in_a22. Output channel out_valid/out_ready carries
// the nine Q16.16 inverse elements, the exact Q26.24 determinant and a status
// code (ok, singular, saturated). Singular matrices give all-zero elements.
// From acceptance to out_valid an item passes the front-end registers for the
// products, adjugate and determinant, then the divider lanes (one quotient
// bit per stage), then the merging output register.
// Throughput is one item per cycle unless a result waits unaccepted at the
// output; the nine lanes divide in parallel and the whole pipeline advances together.
// When the receiver stalls with a result waiting, the pipeline freezes and
// in_ready drops in the same cycle; nothing is lost or repeated.
// Reset clears all valid flags; no item is in flight afterwards and the
// block accepts input as soon as reset is released.
module matrix_inverse_3x3 (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [minv_pkg::ELEM_W-1:0]     in_a00,
  input  logic [minv_pkg::ELEM_W-1:0]     in_a01,
  input  logic [minv_pkg::ELEM_W-1:0]     in_a02,
  input  logic [minv_pkg::ELEM_W-1:0]     in_a10,
  input  logic [minv_pkg::ELEM_W-1:0]     in_a11,
  input  logic [minv_pkg::ELEM_W-1:0]     in_a12,
  input  logic [minv_pkg::ELEM_W-1:0]     in_a20,
  input  logic [minv_pkg::ELEM_W-1:0]     in_a21,
  input  logic [minv_pkg::ELEM_W-1:0]     in_a22,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [minv_pkg::Q_W-1:0]        out_r00,
  output logic [minv_pkg::Q_W-1:0]        out_r01,
  output logic [minv_pkg::Q_W-1:0]        out_r02,
  output logic [minv_pkg::Q_W-1:0]        out_r10,
  output logic [minv_pkg::Q_W-1:0]        out_r11,
  output logic [minv_pkg::Q_W-1:0]        out_r12,
  output logic [minv_pkg::Q_W-1:0]        out_r20,
  output logic [minv_pkg::Q_W-1:0]        out_r21,
  output logic [minv_pkg::Q_W-1:0]        out_r22,
  output logic [minv_pkg::DETO_W-1:0]     out_det_value,
  output logic [1:0]                      out_status
);

  localparam int unsigned NE = minv_pkg::N_ELEM;
  localparam int unsigned QW = minv_pkg::Q_W;

  logic                                   en;
  logic [NE-1:0][minv_pkg::ELEM_W-1:0]    elem;
  minv_pkg::front_out_t                   fo;
  logic [NE-1:0][QW-1:0]                  lres;
  logic [NE-1:0]                          lsat;
  logic [minv_pkg::PIPE_LAT-1:0]          v_r;
  logic signed [minv_pkg::DET_W-1:0]      det_d_r  [minv_pkg::LANE_LAT];
  logic                                   zero_d_r [minv_pkg::LANE_LAT];
  logic                                   out_valid_r;
  logic [NE-1:0][QW-1:0]                  res_r;
  logic [NE-1:0][QW-1:0]                  res_nxt;
  logic [minv_pkg::DETO_W-1:0]            det_o_r;
  minv_pkg::status_t                      status_r;
  minv_pkg::status_t                      status_nxt;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  assign elem = {in_a22, in_a21, in_a20, in_a12, in_a11, in_a10, in_a02, in_a01, in_a00};

  minv_front u_front (
    .clk  (clk),
    .en   (en),
    .elem (elem),
    .fo   (fo)
  );

  for (genvar k = 0; k < NE; k++) begin : g_lane
    minv_lane u_lane (
      .clk  (clk),
      .en   (en),
      .mag  (fo.mag[k]),
      .dmag (fo.dmag),
      .neg  (fo.neg[k]),
      .res  (lres[k]),
      .sat  (lsat[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[minv_pkg::PIPE_LAT-2:0], in_valid};
      out_valid_r <= v_r[minv_pkg::PIPE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_d_r[0]  <= fo.det;
      zero_d_r[0] <= fo.zero;
      for (int s = 1; s < minv_pkg::LANE_LAT; s++) begin
        det_d_r[s]  <= det_d_r[s-1];
        zero_d_r[s] <= zero_d_r[s-1];
      end
      res_r    <= res_nxt;
      det_o_r  <= minv_pkg::DETO_W'(det_d_r[minv_pkg::LANE_LAT-1]);
      status_r <= status_nxt;
    end
  end

  always_comb begin
    if (zero_d_r[minv_pkg::LANE_LAT-1]) begin
      res_nxt    = '0;
      status_nxt = minv_pkg::ST_SINGULAR;
    end else begin
      res_nxt    = lres;
      status_nxt = (|lsat) ? minv_pkg::ST_SAT : minv_pkg::ST_OK;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_r00       = res_r[0];
  assign out_r01       = res_r[1];
  assign out_r02       = res_r[2];
  assign out_r10       = res_r[3];
  assign out_r11       = res_r[4];
  assign out_r12       = res_r[5];
  assign out_r20       = res_r[6];
  assign out_r21       = res_r[7];
  assign out_r22       = res_r[8];
  assign out_det_value = det_o_r;
  assign out_status    = status_r;

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v_r[0])
    else $error("accepted item did not enter the pipeline");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == minv_pkg::ST_SINGULAR) |-> (res_r == '0 && det_o_r == '0))
    else $error("singular result with nonzero elements or determinant");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != 2'd3))
    else $error("undefined status code");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (v_r == $past(v_r)))
    else $error("pipeline moved during output stall");

endmodule

### tb/sv/tb_matrix_inverse_3x3.sv
// Testbench for the 3x3 fixed-point matrix inverse: directed table, random matrices, scoreboard.
module tb_matrix_inverse_3x3;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0] a [9];
  } matrix_t;

  typedef struct {
    logic [31:0]       r [9];
    logic [49:0]       det;
    minv_pkg::status_t status;
  } inverse_t;

  typedef struct {
    logic [15:0]       a [9];
    logic              known;
    logic [31:0]       r [9];
    logic [49:0]       det;
    minv_pkg::status_t status;
  } stim_row_t;

  localparam int N_RANDOM = 880;
  localparam int WATCHDOG = 20000;
  localparam int DRAIN    = 2 * minv_pkg::PIPE_LAT + 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_a [9];
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_r [9];
  logic [49:0] out_det_value;
  logic [1:0] out_status;

  inverse_t expected_inverses[$];
  int errors = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;
  bit calm = 1'b0;
  bit hold_off = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial for (int i = 0; i < 9; i++) in_a[i] = '0;

  matrix_inverse_3x3 i_dut (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_a00(in_a[0]), .in_a01(in_a[1]), .in_a02(in_a[2]),
    .in_a10(in_a[3]), .in_a11(in_a[4]), .in_a12(in_a[5]),
    .in_a20(in_a[6]), .in_a21(in_a[7]), .in_a22(in_a[8]),
    .out_valid, .out_ready,
    .out_r00(out_r[0]), .out_r01(out_r[1]), .out_r02(out_r[2]),
    .out_r10(out_r[3]), .out_r11(out_r[4]), .out_r12(out_r[5]),
    .out_r20(out_r[6]), .out_r21(out_r[7]), .out_r22(out_r[8]),
    .out_det_value, .out_status
  );

  function automatic inverse_t invert_matrix(matrix_t m);
    inverse_t res;
    longint x [9];
    longint adj [9];
    logic signed [127:0] det, dmag, num, quo;
    logic dneg, neg, sat;
    sat = 1'b0;
    for (int i = 0; i < 9; i++) x[i] = longint'($signed(m.a[i]));
    adj[0] = x[4] * x[8] - x[5] * x[7];
    adj[1] = x[2] * x[7] - x[1] * x[8];
    adj[2] = x[1] * x[5] - x[2] * x[4];
    adj[3] = x[5] * x[6] - x[3] * x[8];
    adj[4] = x[0] * x[8] - x[2] * x[6];
    adj[5] = x[2] * x[3] - x[0] * x[5];
    adj[6] = x[3] * x[7] - x[4] * x[6];
    adj[7] = x[1] * x[6] - x[0] * x[7];
    adj[8] = x[0] * x[4] - x[1] * x[3];
    det = 128'(x[0]) * 128'(adj[0]) + 128'(x[1]) * 128'(adj[3]) + 128'(x[2]) * 128'(adj[6]);
    res.det = det[49:0];
    if (det == 0) begin
      for (int i = 0; i < 9; i++) res.r[i] = '0;
      res.status = minv_pkg::ST_SINGULAR;
      return res;
    end
    dneg = det < 0;
    dmag = dneg ? -det : det;
    for (int i = 0; i < 9; i++) begin
      neg = (adj[i] < 0) != dneg;
      num = (adj[i] < 0 ? -128'(adj[i]) : 128'(adj[i])) <<< minv_pkg::FRAC;
      quo = num / dmag;
      if (quo > (neg ? 128'sh8000_0000 : 128'sh7FFF_FFFF)) begin
        sat = 1'b1;
        res.r[i] = neg ? minv_pkg::SAT_NEG : minv_pkg::SAT_POS;
      end else begin
        res.r[i] = neg ? -quo[31:0] : quo[31:0];
      end
    end
    res.status = sat ? minv_pkg::ST_SAT : minv_pkg::ST_OK;
    return res;
  endfunction

  function automatic stim_row_t row_of(logic [15:0] a0, logic [15:0] a1, logic [15:0] a2,
                                       logic [15:0] a3, logic [15:0] a4, logic [15:0] a5,
                                       logic [15:0] a6, logic [15:0] a7, logic [15:0] a8);
    stim_row_t row;
    row.a = '{a0, a1, a2, a3, a4, a5, a6, a7, a8};
    row.known = 1'b0;
    return row;
  endfunction

  function automatic stim_row_t known_row(stim_row_t row, logic [31:0] diag, logic [49:0] det,
                                          minv_pkg::status_t st);
    row.known = 1'b1;
    for (int i = 0; i < 9; i++) row.r[i] = (i % 4 == 0) ? diag : '0;
    row.det = det;
    row.status = st;
    return row;
  endfunction

  task automatic send_matrix(matrix_t m);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_a = m.a;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_inverses.push_back(invert_matrix(m));
    @(negedge clk);
  endtask

  function automatic logic [15:0] random_elem();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 1) ? 16'h8000 : 16'h7FFF);
      1: return 16'($signed($urandom_range(0, 8)) - 4);
      2: return 16'($signed($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    stim_row_t table_rows[$];
    matrix_t m;
    table_rows.push_back(known_row(row_of(0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0,
                                   minv_pkg::ST_SINGULAR));
    table_rows.push_back(known_row(row_of(256, 0, 0, 0, 256, 0, 0, 0, 256),
                                   32'h0001_0000, 50'h100_0000, minv_pkg::ST_OK));
    table_rows.push_back(known_row(row_of(1, 0, 0, 0, 1, 0, 0, 0, 1),
                                   32'h0100_0000, 50'd1, minv_pkg::ST_OK));
    table_rows.push_back(known_row(row_of(16'hFFFF, 0, 0, 0, 16'hFFFF, 0, 0, 0, 16'hFFFF),
                                   32'hFF00_0000, {50{1'b1}}, minv_pkg::ST_OK));
    table_rows.push_back(known_row(row_of(1, 2, 3, 2, 4, 6, 7, 8, 9), 0, 0,
                                   minv_pkg::ST_SINGULAR));
    table_rows.push_back(row_of(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                16'h8000, 16'h8000, 16'h8000, 16'h8000));
    table_rows.push_back(row_of(16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000,
                                16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000));
    table_rows.push_back(row_of(16'h7FFF, 16'h8000, 0, 16'h8000, 16'h7FFF, 0, 0, 0, 16'h7FFF));
    table_rows.push_back(row_of(16'h8000, 0, 0, 0, 16'h8000, 0, 0, 0, 16'h8000));
    table_rows.push_back(row_of(0, 256, 0, 0, 0, 256, 256, 0, 0));
    table_rows.push_back(row_of(512, 0, 0, 0, 512, 0, 0, 0, 512));
    table_rows.push_back(row_of(16'hFF00, 3, 5, 7, 16'hFE00, 11, 13, 17, 19));
    table_rows.push_back(row_of(16'h7FFF, 1, 0, 0, 16'h7FFF, 1, 1, 0, 16'h7FFF));
    table_rows.push_back(row_of(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                                16'h5555, 16'hAAAA, 16'h5555, 16'h5A5A));
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (table_rows[k]) begin
      m.a = table_rows[k].a;
      if (table_rows[k].known) begin
        inverse_t pred;
        pred = invert_matrix(m);
        for (int i = 0; i < 9; i++)
          if (pred.r[i] !== table_rows[k].r[i]) begin
            $error("table row %0d r%0d%0d: expected %h actual %h", k, i / 3, i % 3,
                   table_rows[k].r[i], pred.r[i]);
            errors++;
          end
        if (pred.det !== table_rows[k].det) begin
          $error("table row %0d det_value: expected %h actual %h", k, table_rows[k].det,
                 pred.det);
          errors++;
        end
        if (pred.status !== table_rows[k].status) begin
          $error("table row %0d status: expected %0d actual %0d", k, table_rows[k].status,
                 pred.status);
          errors++;
        end
      end
      send_matrix(m);
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 200) hold_off = 1'b1;
      if (n == N_RANDOM - 150) calm = 1'b1;
      for (int i = 0; i < 9; i++) m.a[i] = random_elem();
      if ($urandom_range(0, 9) == 0) begin
        m.a[6] = m.a[0];
        m.a[7] = m.a[1];
        m.a[8] = m.a[2];
      end
      send_matrix(m);
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    int stall;
    bit held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        stall = 0;
        while (stall < 300) begin
          @(negedge clk);
          stall++;
        end
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_inverses.size() == 0) begin
        $error("result with no matrix pending");
        errors++;
      end else begin
        inverse_t exp_inv;
        exp_inv = expected_inverses.pop_front();
        for (int i = 0; i < 9; i++)
          if (out_r[i] !== exp_inv.r[i]) begin
            $error("r%0d%0d: expected %h actual %h", i / 3, i % 3, exp_inv.r[i], out_r[i]);
            errors++;
          end
        if (out_det_value !== exp_inv.det) begin
          $error("det_value: expected %h actual %h", exp_inv.det, out_det_value);
          errors++;
        end
        if (out_status !== exp_inv.status) begin
          $error("status: expected %0d actual %0d", exp_inv.status, out_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(posedge rst_n);
    fork
      begin
        wait (stim_done && expected_inverses.size() == 0);
        repeat (DRAIN) @(posedge clk);
      end
      begin
        wait (idle_cycles >= WATCHDOG);
        $display("watchdog: no progress");
        errors++;
      end
    join_any
    if (errors == 0 && expected_inverses.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
